FILE: src/rvdec_pkg.sv
// rvdec_pkg: types and codes for the rv32i instruction decoder
// transaction structs, major opcode codes, class and format codes
// no dependencies
`default_nettype none

package rvdec_pkg;

    typedef struct packed {
        logic [31:0] instr_word;
        logic [31:0] fetch_pc;
        logic        fetch_valid;
    } t_dec_in;

    typedef struct packed {
        logic [31:0] out_pc;
        logic [4:0]  dest_reg;
        logic [4:0]  src1_reg;
        logic [4:0]  src2_reg;
        logic [31:0] immediate;
        logic        out_valid;
        logic        illegal_op;
        logic        is_jump;
        logic        jump_via_reg;
        logic        writes_dest;
        logic        reads_src1;
        logic        reads_src2;
    } t_dec_out;

    // major opcode, instruction bits 6:2
    localparam logic [4:0] OPC_LOAD   = 5'b00000;
    localparam logic [4:0] OPC_OPIMM  = 5'b00100;
    localparam logic [4:0] OPC_AUIPC  = 5'b00101;
    localparam logic [4:0] OPC_STORE  = 5'b01000;
    localparam logic [4:0] OPC_OP     = 5'b01100;
    localparam logic [4:0] OPC_LUI    = 5'b01101;
    localparam logic [4:0] OPC_BRANCH = 5'b11000;
    localparam logic [4:0] OPC_JALR   = 5'b11001;
    localparam logic [4:0] OPC_JAL    = 5'b11011;
    localparam logic [4:0] OPC_SYSTEM = 5'b11100;

    localparam logic [1:0] LOW_BITS_32 = 2'b11;

    localparam logic [3:0] CLS_INVALID = 4'd0;
    localparam logic [3:0] CLS_LOAD    = 4'd1;
    localparam logic [3:0] CLS_OPIMM   = 4'd2;
    localparam logic [3:0] CLS_AUIPC   = 4'd3;
    localparam logic [3:0] CLS_STORE   = 4'd4;
    localparam logic [3:0] CLS_OP      = 4'd5;
    localparam logic [3:0] CLS_LUI     = 4'd6;
    localparam logic [3:0] CLS_BRANCH  = 4'd7;
    localparam logic [3:0] CLS_JALR    = 4'd8;
    localparam logic [3:0] CLS_JAL     = 4'd9;
    localparam logic [3:0] CLS_SYSTEM  = 4'd10;

    localparam logic [2:0] FMT_NONE = 3'd0;
    localparam logic [2:0] FMT_R    = 3'd1;
    localparam logic [2:0] FMT_I    = 3'd2;
    localparam logic [2:0] FMT_S    = 3'd3;
    localparam logic [2:0] FMT_B    = 3'd4;
    localparam logic [2:0] FMT_U    = 3'd5;
    localparam logic [2:0] FMT_J    = 3'd6;

endpackage

`default_nettype wire

FILE: src/rv32i_instruction_decoder_unit.sv
// rv32i_instruction_decoder_unit: top level of the rv32i instruction decoder
// input register, decode logic, result register
// depends on rvdec_pkg and rvdec_decode
//
// input channel: i_valid / o_stall with i_data (rvdec_pkg::t_dec_in); a transaction
// is taken at a rising edge with i_valid high and o_stall low
// output channel: o_valid / i_stall with o_data (rvdec_pkg::t_dec_out); one result
// transaction for every input transaction, in order
// a transaction passes through the input register and the result register, with the
// decode logic between them
// throughput: one transaction per cycle while i_stall stays low
// while i_stall is high the result register holds its contents; the input
// register still takes one more transaction, and o_stall rises only once
// both registers are full
// reset (i_rst_n low, synchronous) empties both registers; o_valid is low after
`default_nettype none

module rv32i_instruction_decoder_unit (
    input  var logic                i_clk,
    input  var logic                i_rst_n,
    input  var logic                i_valid,
    output var logic                o_stall,
    input  var rvdec_pkg::t_dec_in  i_data,
    output var logic                o_valid,
    input  var logic                i_stall,
    output var rvdec_pkg::t_dec_out o_data
);

    logic                r_in_valid;
    logic                n_in_valid;
    rvdec_pkg::t_dec_in  r_in_data;
    logic                r_out_valid;
    logic                n_out_valid;
    rvdec_pkg::t_dec_out r_out_data;
    rvdec_pkg::t_dec_out dec_result;
    logic                out_ready;
    logic                in_ready;

    assign out_ready = !r_out_valid || !i_stall;
    assign in_ready  = !r_in_valid || out_ready;

    rvdec_decode u_decode (
        .i_item   (r_in_data),
        .o_result (dec_result)
    );

    always_comb begin
        n_in_valid  = in_ready ? i_valid : r_in_valid;
        n_out_valid = out_ready ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_in_data <= i_data;
        end
        if (out_ready && r_in_valid) begin
            r_out_data <= dec_result;
        end
    end

    assign o_stall = !in_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

`default_nettype wire

FILE: src/rvdec_decode.sv
// rvdec_decode: combinational decode of one rv32i instruction
// class, format, immediate, register-use and jump flags
// depends on rvdec_pkg
`default_nettype none

module rvdec_decode (
    input  var rvdec_pkg::t_dec_in  i_item,
    output var rvdec_pkg::t_dec_out o_result
);

    logic [31:0] w;
    logic [3:0]  cls;
    logic [2:0]  fmt;
    logic [31:0] imm;
    logic        known;

    assign w = i_item.instr_word;

    always_comb begin
        unique case (w[6:2])
            rvdec_pkg::OPC_LOAD:   cls = rvdec_pkg::CLS_LOAD;
            rvdec_pkg::OPC_OPIMM:  cls = rvdec_pkg::CLS_OPIMM;
            rvdec_pkg::OPC_AUIPC:  cls = rvdec_pkg::CLS_AUIPC;
            rvdec_pkg::OPC_STORE:  cls = rvdec_pkg::CLS_STORE;
            rvdec_pkg::OPC_OP:     cls = rvdec_pkg::CLS_OP;
            rvdec_pkg::OPC_LUI:    cls = rvdec_pkg::CLS_LUI;
            rvdec_pkg::OPC_BRANCH: cls = rvdec_pkg::CLS_BRANCH;
            rvdec_pkg::OPC_JALR:   cls = rvdec_pkg::CLS_JALR;
            rvdec_pkg::OPC_JAL:    cls = rvdec_pkg::CLS_JAL;
            rvdec_pkg::OPC_SYSTEM: cls = rvdec_pkg::CLS_SYSTEM;
            default:               cls = rvdec_pkg::CLS_INVALID;
        endcase
    end

    always_comb begin
        if (w[1:0] != rvdec_pkg::LOW_BITS_32) begin
            fmt = rvdec_pkg::FMT_NONE;
        end else begin
            unique case (cls) inside
                rvdec_pkg::CLS_LOAD, rvdec_pkg::CLS_OPIMM,
                rvdec_pkg::CLS_JALR:   fmt = rvdec_pkg::FMT_I;
                rvdec_pkg::CLS_AUIPC,
                rvdec_pkg::CLS_LUI:    fmt = rvdec_pkg::FMT_U;
                rvdec_pkg::CLS_STORE:  fmt = rvdec_pkg::FMT_S;
                rvdec_pkg::CLS_OP:     fmt = rvdec_pkg::FMT_R;
                rvdec_pkg::CLS_BRANCH: fmt = rvdec_pkg::FMT_B;
                rvdec_pkg::CLS_JAL:    fmt = rvdec_pkg::FMT_J;
                default:               fmt = rvdec_pkg::FMT_NONE;
            endcase
        end
    end

    always_comb begin
        unique case (fmt)
            rvdec_pkg::FMT_I: imm = {{20{w[31]}}, w[31:20]};
            rvdec_pkg::FMT_S: imm = {{20{w[31]}}, w[31:25], w[11:7]};
            rvdec_pkg::FMT_B: imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            rvdec_pkg::FMT_U: imm = {w[31:12], 12'b0};
            rvdec_pkg::FMT_J: imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            default:          imm = 32'b0;
        endcase
    end

    assign known = (cls != rvdec_pkg::CLS_INVALID);

    always_comb begin
        o_result.out_pc       = i_item.fetch_pc;
        o_result.dest_reg     = w[11:7];
        o_result.src1_reg     = w[19:15];
        o_result.src2_reg     = w[24:20];
        o_result.immediate    = imm;
        o_result.out_valid    = known && i_item.fetch_valid;
        o_result.illegal_op   = !known && i_item.fetch_valid;
        o_result.is_jump      = (cls == rvdec_pkg::CLS_BRANCH) || (cls == rvdec_pkg::CLS_JAL)
                             || (cls == rvdec_pkg::CLS_JALR) || (cls == rvdec_pkg::CLS_SYSTEM);
        o_result.jump_via_reg = (cls == rvdec_pkg::CLS_JALR);
        o_result.writes_dest  = (w[11:7] != 5'd0)
                             && ((fmt == rvdec_pkg::FMT_R) || (fmt == rvdec_pkg::FMT_I)
                             || (fmt == rvdec_pkg::FMT_U) || (fmt == rvdec_pkg::FMT_J));
        o_result.reads_src1   = (w[19:15] != 5'd0)
                             && ((fmt == rvdec_pkg::FMT_R) || (fmt == rvdec_pkg::FMT_I)
                             || (fmt == rvdec_pkg::FMT_S) || (fmt == rvdec_pkg::FMT_B));
        o_result.reads_src2   = (w[24:20] != 5'd0)
                             && ((fmt == rvdec_pkg::FMT_R) || (fmt == rvdec_pkg::FMT_S)
                             || (fmt == rvdec_pkg::FMT_B));
    end

endmodule

`default_nettype wire

FILE: src/rvdec_checker.sv
// rvdec_checker: port-level assertions for rv32i_instruction_decoder_unit
// bound to the top level by the bind statement at the end of this file
// depends on rvdec_pkg
`default_nettype none

module rvdec_checker (
    input var logic                i_clk,
    input var logic                i_rst_n,
    input var logic                o_valid,
    input var logic                i_stall,
    input var rvdec_pkg::t_dec_out o_data
);

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_valid_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.out_valid && o_data.illegal_op))
        else $error("decoded both recognized and illegal");

    a_jalr_jump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.jump_via_reg |-> o_data.is_jump)
        else $error("register jump not flagged as jump");

    a_dest_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.writes_dest |-> o_data.dest_reg != 5'd0)
        else $error("write flagged for register zero");

endmodule

bind rv32i_instruction_decoder_unit rvdec_checker u_rvdec_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire

FILE: tb/rv32i_instruction_decoder_unit_tb.sv
// rv32i_instruction_decoder_unit_tb: self-checking testbench for the rv32i decoder
// directed and random instruction words with random idling, checked against a decode predictor
// depends on rvdec_pkg and rv32i_instruction_decoder_unit
module rv32i_instruction_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;

    class decode_scoreboard;
        rvdec_pkg::t_dec_out expected_decodes[$];
        int                  mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        function rvdec_pkg::t_dec_out decode_instr(rvdec_pkg::t_dec_in d);
            logic [31:0]         w;
            logic [3:0]          cls;
            logic [2:0]          fmt;
            rvdec_pkg::t_dec_out r;
            w = d.instr_word;
            case (w[6:2])
                rvdec_pkg::OPC_LOAD:   cls = rvdec_pkg::CLS_LOAD;
                rvdec_pkg::OPC_OPIMM:  cls = rvdec_pkg::CLS_OPIMM;
                rvdec_pkg::OPC_AUIPC:  cls = rvdec_pkg::CLS_AUIPC;
                rvdec_pkg::OPC_STORE:  cls = rvdec_pkg::CLS_STORE;
                rvdec_pkg::OPC_OP:     cls = rvdec_pkg::CLS_OP;
                rvdec_pkg::OPC_LUI:    cls = rvdec_pkg::CLS_LUI;
                rvdec_pkg::OPC_BRANCH: cls = rvdec_pkg::CLS_BRANCH;
                rvdec_pkg::OPC_JALR:   cls = rvdec_pkg::CLS_JALR;
                rvdec_pkg::OPC_JAL:    cls = rvdec_pkg::CLS_JAL;
                rvdec_pkg::OPC_SYSTEM: cls = rvdec_pkg::CLS_SYSTEM;
                default:               cls = rvdec_pkg::CLS_INVALID;
            endcase
            case (cls) inside
                rvdec_pkg::CLS_LOAD, rvdec_pkg::CLS_OPIMM,
                rvdec_pkg::CLS_JALR:   fmt = rvdec_pkg::FMT_I;
                rvdec_pkg::CLS_AUIPC,
                rvdec_pkg::CLS_LUI:    fmt = rvdec_pkg::FMT_U;
                rvdec_pkg::CLS_STORE:  fmt = rvdec_pkg::FMT_S;
                rvdec_pkg::CLS_OP:     fmt = rvdec_pkg::FMT_R;
                rvdec_pkg::CLS_BRANCH: fmt = rvdec_pkg::FMT_B;
                rvdec_pkg::CLS_JAL:    fmt = rvdec_pkg::FMT_J;
                default:               fmt = rvdec_pkg::FMT_NONE;
            endcase
            if (w[1:0] != rvdec_pkg::LOW_BITS_32) begin
                fmt = rvdec_pkg::FMT_NONE;
            end
            r.out_pc   = d.fetch_pc;
            r.dest_reg = w[11:7];
            r.src1_reg = w[19:15];
            r.src2_reg = w[24:20];
            case (fmt)
                rvdec_pkg::FMT_I: r.immediate = {{20{w[31]}}, w[31:20]};
                rvdec_pkg::FMT_S: r.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
                rvdec_pkg::FMT_B:
                    r.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                rvdec_pkg::FMT_U: r.immediate = {w[31:12], 12'b0};
                rvdec_pkg::FMT_J:
                    r.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                default:          r.immediate = '0;
            endcase
            r.out_valid    = (cls != rvdec_pkg::CLS_INVALID) && d.fetch_valid;
            r.illegal_op   = (cls == rvdec_pkg::CLS_INVALID) && d.fetch_valid;
            r.is_jump      = (cls == rvdec_pkg::CLS_BRANCH) || (cls == rvdec_pkg::CLS_JAL) ||
                             (cls == rvdec_pkg::CLS_JALR) || (cls == rvdec_pkg::CLS_SYSTEM);
            r.jump_via_reg = (cls == rvdec_pkg::CLS_JALR);
            r.writes_dest  = (r.dest_reg != 5'd0) &&
                             (fmt == rvdec_pkg::FMT_R || fmt == rvdec_pkg::FMT_I ||
                              fmt == rvdec_pkg::FMT_U || fmt == rvdec_pkg::FMT_J);
            r.reads_src1   = (r.src1_reg != 5'd0) &&
                             (fmt == rvdec_pkg::FMT_R || fmt == rvdec_pkg::FMT_I ||
                              fmt == rvdec_pkg::FMT_S || fmt == rvdec_pkg::FMT_B);
            r.reads_src2   = (r.src2_reg != 5'd0) &&
                             (fmt == rvdec_pkg::FMT_R || fmt == rvdec_pkg::FMT_S ||
                              fmt == rvdec_pkg::FMT_B);
            return r;
        endfunction

        function void note_instr(rvdec_pkg::t_dec_in d);
            expected_decodes.push_back(decode_instr(d));
        endfunction

        function void compare_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0h, got %0h", fname, exp_v, act_v);
                mismatch_count++;
            end
        endfunction

        function void check_decoded(rvdec_pkg::t_dec_out got);
            rvdec_pkg::t_dec_out want;
            if (expected_decodes.size() == 0) begin
                $error("decode transaction with none outstanding: %0h", got);
                mismatch_count++;
                return;
            end
            want = expected_decodes.pop_front();
            compare_field("out_pc", want.out_pc, got.out_pc);
            compare_field("dest_reg", 32'(want.dest_reg), 32'(got.dest_reg));
            compare_field("src1_reg", 32'(want.src1_reg), 32'(got.src1_reg));
            compare_field("src2_reg", 32'(want.src2_reg), 32'(got.src2_reg));
            compare_field("immediate", want.immediate, got.immediate);
            compare_field("out_valid", 32'(want.out_valid), 32'(got.out_valid));
            compare_field("illegal_op", 32'(want.illegal_op), 32'(got.illegal_op));
            compare_field("is_jump", 32'(want.is_jump), 32'(got.is_jump));
            compare_field("jump_via_reg", 32'(want.jump_via_reg), 32'(got.jump_via_reg));
            compare_field("writes_dest", 32'(want.writes_dest), 32'(got.writes_dest));
            compare_field("reads_src1", 32'(want.reads_src1), 32'(got.reads_src1));
            compare_field("reads_src2", 32'(want.reads_src2), 32'(got.reads_src2));
        endfunction

        function int pending();
            return expected_decodes.size();
        endfunction
    endclass

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                i_stall = 1'b0;
    rvdec_pkg::t_dec_in  i_data  = '0;
    logic                o_stall;
    logic                o_valid;
    rvdec_pkg::t_dec_out o_data;

    decode_scoreboard sb = new();

    bit tx_idling = 1'b0;
    bit rx_idling = 1'b0;
    bit hold_req  = 1'b0;
    int quiet_cycles = 0;

    logic [4:0] major_ops [10] = '{rvdec_pkg::OPC_LOAD, rvdec_pkg::OPC_OPIMM,
                                   rvdec_pkg::OPC_AUIPC, rvdec_pkg::OPC_STORE,
                                   rvdec_pkg::OPC_OP, rvdec_pkg::OPC_LUI,
                                   rvdec_pkg::OPC_BRANCH, rvdec_pkg::OPC_JALR,
                                   rvdec_pkg::OPC_JAL, rvdec_pkg::OPC_SYSTEM};

    always #5 i_clk = ~i_clk;

    rv32i_instruction_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            sb.note_instr(i_data);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_decoded(o_data);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver side: random stall bursts and one long hold
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else if (rx_idling && $urandom_range(0, 6) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    function automatic rvdec_pkg::t_dec_in make_instr(logic [31:0] w, logic [31:0] pc,
                                                      logic vld);
        rvdec_pkg::t_dec_in d;
        d.instr_word  = w;
        d.fetch_pc    = pc;
        d.fetch_valid = vld;
        return d;
    endfunction

    function automatic rvdec_pkg::t_dec_in random_instr();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 7) != 0) begin
            w[6:2] = major_ops[$urandom_range(0, 9)];
        end
        w[1:0] = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 2))
                                             : rvdec_pkg::LOW_BITS_32;
        if ($urandom_range(0, 7) == 0) w[11:7] = '0;
        if ($urandom_range(0, 7) == 0) w[19:15] = '0;
        if ($urandom_range(0, 7) == 0) w[24:20] = '0;
        return make_instr(w, $urandom, $urandom_range(0, 9) != 0);
    endfunction

    task automatic send_instr(rvdec_pkg::t_dec_in d);
        i_valid <= 1'b1;
        i_data  <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic idle_sender(int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic run_random(int count);
        for (int n = 0; n < count; n++) begin
            if (tx_idling && $urandom_range(0, 5) == 0) begin
                idle_sender($urandom_range(1, 18));
            end
            send_instr(random_instr());
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] w;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_instr(make_instr(32'h0000_0000, 32'h0000_0000, 1'b1));
        send_instr(make_instr(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        foreach (major_ops[k]) begin
            w = $urandom | 32'h8000_0000;
            w[6:0] = {major_ops[k], rvdec_pkg::LOW_BITS_32};
            send_instr(make_instr(w, $urandom, 1'b1));
            send_instr(make_instr({25'h100_0000, major_ops[k], rvdec_pkg::LOW_BITS_32},
                                  $urandom, 1'b1));
        end
        send_instr(make_instr({25'h1FF_FFFF, rvdec_pkg::OPC_SYSTEM, 2'b01}, $urandom, 1'b1));
        send_instr(make_instr({25'h0AB_CDEF, rvdec_pkg::OPC_JALR, rvdec_pkg::LOW_BITS_32},
                              $urandom, 1'b0));
        send_instr(make_instr({25'h1FF_FFFF, 5'b11111, rvdec_pkg::LOW_BITS_32},
                              $urandom, 1'b0));

        tx_idling = 1'b1;
        rx_idling = 1'b1;
        run_random(400);

        // long receiver hold with the sender still pushing
        tx_idling = 1'b0;
        hold_req  = 1'b1;
        run_random(40);

        tx_idling = 1'b1;
        run_random(100);
        wait_drained();

        run_random(200);
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        run_random(200);
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        run_random(200);

        tx_idling = 1'b0;
        rx_idling = 1'b0;
        run_random(200);
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
